// File: rtl/core/xkdc_pkg.sv
// ----------------------------------------------------------------------------
// xkdc_pkg
// Shared types, constants and functions of the keystream decryptor with
// CRC-32 check.
// ----------------------------------------------------------------------------
package xkdc_pkg;

    // configuration port geometry
    localparam int unsigned ADDR_W = 4;
    localparam int unsigned DATA_W = 32;

    // crc-32, reflected form
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    // linear congruential term of the keystream
    localparam logic [31:0] LCG_MUL = 32'd1103515245;
    localparam logic [31:0] LCG_ADD = 32'd12345;

    // register word index (byte address / 4)
    typedef enum logic [1:0] {
        REG_KEY_WORD     = 2'd0,
        REG_TARGET_IDENT = 2'd1,
        REG_EXPECTED_CRC = 2'd2
    } xkdc_reg_addr_t;

    // configuration handed from the register file to the datapath
    typedef struct packed {
        logic [31:0] key_word;
        logic [31:0] target_ident;
        logic [31:0] expected_crc;
    } xkdc_cfg_t;

    // fold a 32-bit word down to the keystream byte
    function automatic logic [7:0] ks_fold(input logic [31:0] x);
        logic [31:0] y;
        logic [31:0] z;
        y = x ^ (x >> 16);
        z = y ^ (y >> 8);
        return z[7:0];
    endfunction

    // one byte through the reflected crc-32, eight bit steps unrolled
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                               input logic [7:0]  data);
        logic [31:0] c;
        c = crc_in ^ {24'd0, data};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

endpackage

// File: rtl/core/xkdc_apb_regs.sv
// ----------------------------------------------------------------------------
// xkdc_apb_regs
// Configuration register file behind an APB-style port: key word, target
// identifier and expected CRC.
// ----------------------------------------------------------------------------
module xkdc_apb_regs
    import xkdc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output xkdc_cfg_t         cfg
);

    xkdc_cfg_t      cfg_reg;
    xkdc_cfg_t      cfg_next;
    xkdc_reg_addr_t addr;
    logic           wr_en;

    assign pready = 1'b1;
    assign addr   = xkdc_reg_addr_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    // write decode, unmapped words are ignored
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (addr)
                REG_KEY_WORD:     cfg_next.key_word     = pwdata;
                REG_TARGET_IDENT: cfg_next.target_ident = pwdata;
                REG_EXPECTED_CRC: cfg_next.expected_crc = pwdata;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        case (addr)
            REG_KEY_WORD:     prdata = cfg_reg.key_word;
            REG_TARGET_IDENT: prdata = cfg_reg.target_ident;
            REG_EXPECTED_CRC: prdata = cfg_reg.expected_crc;
            default:          prdata = '0;
        endcase
    end

    // register storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: rtl/core/xor_keystream_decrypt_crc32_check_top.sv
// ----------------------------------------------------------------------------
// xor_keystream_decrypt_crc32_check_top
// Byte-wise XOR keystream decryptor with a running CRC-32 over the plain
// bytes and a pass/fail check against an expected CRC at the package end.
// ----------------------------------------------------------------------------
// The block takes one cipher byte per cycle unless an output stall holds it,
// and returns one plain byte per transaction. The cipher byte is registered in
// the first stage on acceptance, and its result is registered in the second.
// The first register stage holds the cipher byte and its keystream byte,
// whose linear congruential term is kept by an adder stepping once per byte;
// the second stage holds the result and runs the eight unrolled CRC-32 bit
// steps and the compare with the expected CRC. Both stages together buffer
// two transactions; once both are full, in_ready follows out_ready in the
// same cycle, so an output stall stops the input at once. On the byte marked
// final the result carries the inverted CRC and the match flag, and the
// position and CRC restart for the next package.
// The user must write the key, target and expected CRC registers only while idle; the block does not enforce this.
module xor_keystream_decrypt_crc32_check_top
    import xkdc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    // input channel
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        cipher_byte,
    input  logic              final_byte,
    // output channel
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        plain_byte,
    output logic              is_last,
    output logic [31:0]       crc_value,
    output logic              crc_match
);

    xkdc_cfg_t   cfg;

    logic        in_accept;
    logic        s1_adv;

    logic [31:0] lcg_reg;
    logic [31:0] lcg_next;
    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic [7:0]  s1_cipher_reg;
    logic [7:0]  s1_ks_reg;
    logic        s1_final_reg;

    logic [31:0] crc_reg;
    logic [31:0] crc_next;
    logic [7:0]  plain_comb;
    logic [31:0] crc_step;
    logic [31:0] crc_final;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [7:0]  plain_reg;
    logic        last_reg;
    logic [31:0] crc_value_reg;
    logic        crc_match_reg;

    // configuration registers
    xkdc_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // handshake between stages
    assign s1_adv    = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || s1_adv;
    assign in_accept = in_valid && in_ready;

    // stage 1: position term and stage valid
    always_comb
    begin
        lcg_next = lcg_reg;
        if (in_accept)
        begin
            lcg_next = final_byte ? LCG_ADD : (lcg_reg + LCG_MUL);
        end

        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lcg_reg      <= LCG_ADD;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            lcg_reg      <= lcg_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    // stage 1 payload: cipher byte and its keystream byte
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_cipher_reg <= cipher_byte;
            s1_ks_reg     <= ks_fold(cfg.key_word ^ cfg.target_ident ^ lcg_reg);
            s1_final_reg  <= final_byte;
        end
    end

    // stage 2: decrypt, crc update and check
    always_comb
    begin
        plain_comb = s1_cipher_reg ^ s1_ks_reg;
        crc_step   = crc32_byte(crc_reg, plain_comb);
        crc_final  = ~crc_step;

        crc_next = crc_reg;
        if (s1_adv)
        begin
            crc_next = s1_final_reg ? CRC_INIT : crc_step;
        end

        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= CRC_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result register, crc fields zero except on the final byte
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            plain_reg     <= plain_comb;
            last_reg      <= s1_final_reg;
            crc_value_reg <= s1_final_reg ? crc_final : 32'd0;
            crc_match_reg <= s1_final_reg && (crc_final == cfg.expected_crc);
        end
    end

    assign out_valid  = out_valid_reg;
    assign plain_byte = plain_reg;
    assign is_last    = last_reg;
    assign crc_value  = crc_value_reg;
    assign crc_match  = crc_match_reg;

    // checks
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && out_valid_reg))
        else $error("input stalled while a stage is free");

    a_pos_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && final_byte) |=> (lcg_reg == LCG_ADD))
        else $error("position term not restarted after final byte");

    a_crc_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_final_reg) |=> (crc_reg == CRC_INIT))
        else $error("crc not restarted after final byte");

    a_crc_fields_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !is_last) |-> ((crc_value == 32'd0) && !crc_match))
        else $error("crc fields set on a byte that is not the last");

endmodule
